// ===== design/swec_pkg.sv =====
// ----------------------------------------------------------------------------
// swec_pkg
// shared constants for the sliding window event counter
// ----------------------------------------------------------------------------
package swec_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int TIME_BITS_DEFAULT = 40;
   localparam int WINDOW_BITS       = 20;
   localparam int COUNT_BITS        = 7;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 20'd10800;

endpackage

// ===== design/swec_if.sv =====
// ----------------------------------------------------------------------------
// swec channel interfaces
// valid/ready channels for event beats, count beats and window writes
// ----------------------------------------------------------------------------
interface swec_req_if #(parameter int TIME_BITS = swec_pkg::TIME_BITS_DEFAULT) ();
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] event_time;

   modport source (output valid, output event_time, input ready);
   modport sink   (input valid, input event_time, output ready);
endinterface

interface swec_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic [swec_pkg::COUNT_BITS-1:0]  events_in_window;

   modport source (output valid, output events_in_window, input ready);
   modport sink   (input valid, input events_in_window, output ready);
endinterface

interface swec_csr_if ();
   logic                             valid;
   logic                             ready;
   logic [swec_pkg::WINDOW_BITS-1:0] window_seconds;

   modport source (output valid, output window_seconds, input ready);
   modport sink   (input valid, input window_seconds, output ready);
endinterface

// ===== design/sliding_window_event_counter_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_event_counter_unit
// keeps the last DEPTH event stamps in a ring memory and counts those that
// lie within the configured window of each new event
// ----------------------------------------------------------------------------
// Each event beat is written into a ring memory of DEPTH stamps (the oldest
// is overwritten once the ring is full), then every valid entry is read back
// through the single read port, one per cycle, and compared with the new
// stamp. The count beat is loaded into the output register after the scan,
// drain and finish states; finish waits while the previous count is still
// unaccepted, and the next event beat is taken once the block is back in
// idle. A new event is taken while the previous count still waits
// in the output register. Stamps equal to or later than the new one always
// count; the count is reported in its low 7 bits. Window writes are taken on
// every cycle and take effect on the next cycle, so they belong between events.
module sliding_window_event_counter_unit #(
   parameter int DEPTH     = swec_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = swec_pkg::TIME_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   swec_req_if.sink   req_if,
   swec_rsp_if.source rsp_if,
   swec_csr_if.sink   csr_if
);
   import swec_pkg::*;

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(DEPTH);

   logic [TIME_BITS-1:0] stamp_mem [DEPTH];

   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [TIME_BITS-1:0]   rd_data_ff;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [FILL_W-1:0]      cnt_ff, cnt_in;
   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   hit;
   logic                   load_rsp;
   logic [CMP_W-1:0]       diff;
   logic [FILL_W+COUNT_BITS-1:0] cnt_ext;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.events_in_window = rsp_count_ff;

   assign diff    = CMP_W'(now_ff) - CMP_W'(rd_data_ff);
   assign hit     = rd_vld_ff && ((rd_data_ff >= now_ff) || (diff <= CMP_W'(window_ff)));
   assign cnt_ext = {{COUNT_BITS{1'b0}}, cnt_ff};
   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      now_in       = now_ff;
      cnt_in       = hit ? cnt_ff + 1'b1 : cnt_ff;
      window_in    = csr_if.valid ? csr_if.window_seconds : window_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in    = req_if.event_time;
               wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
               fill_in   = (fill_ff < FILL_FULL) ? fill_ff + 1'b1 : fill_ff;
               rd_idx_in = '0;
               cnt_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            if (FILL_W'(rd_idx_ff) == fill_ff - 1'b1) begin
               state_in = S_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (load_rsp) begin
               rsp_count_in = cnt_ext[COUNT_BITS-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stamp_mem[wr_ptr_ff] <= req_if.event_time;
      end
      rd_data_ff <= stamp_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      now_ff       <= now_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond depth");

   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (FILL_W'(rd_idx_ff) < fill_ff))
      else $error("read beyond written entries");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("count beat raised outside finish");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (DEPTH < 128)) |-> (rsp_count_ff != '0))
      else $error("new event missing from its own count");

   a_hit_only_scanning: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(state_ff) == S_SCAN))
      else $error("read data valid outside scan");
`endif

endmodule

// ===== verif/event_count_checker.sv =====
// ----------------------------------------------------------------------------
// event_count_checker
// watches the event, count and window channels of the sliding window event
// counter, predicts each count from its own stamp history and window setting,
// and compares every count beat with the oldest prediction
// ----------------------------------------------------------------------------
module event_count_checker #(
   parameter int DEPTH     = swec_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = swec_pkg::TIME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [TIME_BITS-1:0]             event_time,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [swec_pkg::COUNT_BITS-1:0]  events_in_window,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [swec_pkg::WINDOW_BITS-1:0] window_seconds,
   output int                               counts_pending,
   output int                               mismatches
);
   timeunit 1ns;
   timeprecision 1ps;
   import swec_pkg::*;

   logic [TIME_BITS-1:0]   stamps [DEPTH];
   int                     stamps_held;
   logic [WINDOW_BITS-1:0] window;
   logic [COUNT_BITS-1:0]  expected_counts [$];
   int                     fails;

   function automatic logic [COUNT_BITS-1:0] count_in_window(logic [TIME_BITS-1:0] now);
      logic [COUNT_BITS-1:0] hits;
      hits = '0;
      if (stamps_held < DEPTH) begin
         stamps[stamps_held] = now;
         stamps_held++;
      end else begin
         for (int i = 0; i < DEPTH - 1; i++)
            stamps[i] = stamps[i + 1];
         stamps[DEPTH - 1] = now;
      end
      // stamps at or after the new one always count
      for (int i = 0; i < stamps_held; i++)
         if (stamps[i] >= now || (64'(now) - 64'(stamps[i])) <= 64'(window))
            hits++;
      return hits;
   endfunction

   initial fails = 0;

   always @(posedge clock) begin
      logic [COUNT_BITS-1:0] want;
      if (reset) begin
         stamps_held = 0;
         window = WINDOW_RESET;
         expected_counts.delete();
      end else begin
         if (csr_valid && csr_ready)
            window = window_seconds;
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $error("events_in_window: no beat expected, actual %0d", events_in_window);
               fails++;
            end else begin
               want = expected_counts.pop_front();
               if (events_in_window !== want) begin
                  $error("events_in_window: expected %0d, actual %0d", want, events_in_window);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_counts.push_back(count_in_window(event_time));
      end
      counts_pending <= expected_counts.size();
      mismatches     <= fails;
   end

endmodule

// ===== verif/tb_sliding_window_event_counter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_event_counter_unit
// drives event beats and window writes into the counter with random idling
// and count stalls; a checker beside the block predicts and compares counts
// ----------------------------------------------------------------------------
module tb_sliding_window_event_counter_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import swec_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int TIME_BITS   = TIME_BITS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 75;

   logic clock;
   logic reset;
   int   counts_pending;
   int   mismatches;
   int   gap_pct;
   bit   quiet;

   swec_req_if #(.TIME_BITS(TIME_BITS)) req_ch ();
   swec_rsp_if                          rsp_ch ();
   swec_csr_if                          csr_ch ();

   sliding_window_event_counter_unit #(
      .DEPTH    (DEPTH),
      .TIME_BITS(TIME_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   event_count_checker #(
      .DEPTH    (DEPTH),
      .TIME_BITS(TIME_BITS)
   ) count_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .event_time      (req_ch.event_time),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .events_in_window(rsp_ch.events_in_window),
      .csr_valid       (csr_ch.valid),
      .csr_ready       (csr_ch.ready),
      .window_seconds  (csr_ch.window_seconds),
      .counts_pending  (counts_pending),
      .mismatches      (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_event(input logic [TIME_BITS-1:0] stamp);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.event_time <= stamp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_counts();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (counts_pending != 0);
   endtask

   task automatic write_window(input logic [WINDOW_BITS-1:0] seconds);
      drain_counts();
      csr_ch.valid          <= 1'b1;
      csr_ch.window_seconds <= seconds;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // mostly bursts of strikes close together, some late arrivals and jumps
   function automatic logic [TIME_BITS-1:0] next_stamp(logic [TIME_BITS-1:0] last,
                                                       int unsigned span);
      int unsigned pick;
      logic [63:0] wide;
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (pick < 55)
         return last + $urandom_range(0, span / 16 + 1);
      else if (pick < 75)
         return last + $urandom_range(0, 2 * span + 2);
      else if (pick < 87)
         return last - $urandom_range(0, span + 1);
      else if (pick < 94)
         return wide[TIME_BITS-1:0];
      else
         return '1 - $urandom_range(0, span + 1);
   endfunction

   initial begin : count_stalls
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [TIME_BITS-1:0]   cur;
      logic [WINDOW_BITS-1:0] win;
      logic [63:0]            wide;
      quiet   = 1'b0;
      gap_pct = 0;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.event_time     <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.window_seconds <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset window: boundary, late stamps, extremes
      send_event(40'd1000);
      send_event(40'd11800);
      send_event(40'd11801);
      send_event(40'd0);
      send_event(40'hFF_FFFF_FFFF);
      send_event(40'hFF_FFFF_FFFF);
      send_event(40'd5);

      write_window('0);
      send_event(40'd100);
      send_event(40'd100);
      send_event(40'd99);
      send_event(40'd101);

      write_window('1);
      send_event(40'h10_0000_0000);
      send_event(40'h10_000F_FFFF);
      send_event(40'h10_0010_0000);
      send_event(40'hFF_FFFF_FFFF);

      write_window(WINDOW_RESET);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: win = '0;
            1: win = '1;
            2: win = 20'd1;
            3: win = WINDOW_RESET;
            4: win = 20'($urandom_range(0, 64));
            default: win = 20'($urandom_range(0, 20'hFFFFF));
         endcase
         write_window(win);
         gap_pct = (phase % 3 == 2) ? 0 : $urandom_range(5, 40);
         quiet   = (phase == PHASES - 1);
         wide    = {$urandom, $urandom};
         cur     = wide[TIME_BITS-1:0];
         for (int k = 0; k < PHASE_BEATS; k++) begin
            cur = next_stamp(cur, win);
            send_event(cur);
         end
      end

      drain_counts();
      repeat (DEPTH + 16) @(posedge clock);
      if (mismatches == 0 && counts_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/swec_pkg.sv
design/swec_if.sv
design/sliding_window_event_counter_unit.sv
verif/event_count_checker.sv
verif/tb_sliding_window_event_counter_unit.sv
